>>> rtl/core/sha_pkg.sv
`default_nettype none
package sha_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_PAD,
        ST_OUT
    } state_t;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/sha_round.sv
`default_nettype none
// one sha-256 round with message schedule step
module sha_round
(
    input  wire logic [31:0] v_in [8],
    input  wire logic [31:0] w_in [16],
    input  wire logic [31:0] k,
    output logic      [31:0] v_out [8],
    output logic      [31:0] w_new
);
    import sha_pkg::*;

    logic [31:0] big0, big1, choose, major, t1, t2, s0, s1;

    always_comb
    begin
        big1   = rotr(v_in[4], 6) ^ rotr(v_in[4], 11) ^ rotr(v_in[4], 25);
        choose = v_in[6] ^ (v_in[4] & (v_in[5] ^ v_in[6]));
        t1     = v_in[7] + big1 + choose + k + w_in[0];
        big0   = rotr(v_in[0], 2) ^ rotr(v_in[0], 13) ^ rotr(v_in[0], 22);
        major  = ((v_in[0] | v_in[1]) & v_in[2]) | (v_in[0] & v_in[1]);
        t2     = big0 + major;
        v_out[7] = v_in[6];
        v_out[6] = v_in[5];
        v_out[5] = v_in[4];
        v_out[4] = v_in[3] + t1;
        v_out[3] = v_in[2];
        v_out[2] = v_in[1];
        v_out[1] = v_in[0];
        v_out[0] = t1 + t2;
        // schedule word sixteen ahead of the current one
        s0 = rotr(w_in[1], 7) ^ rotr(w_in[1], 18) ^ (w_in[1] >> 3);
        s1 = rotr(w_in[14], 17) ^ rotr(w_in[14], 19) ^ (w_in[14] >> 10);
        w_new = s1 + w_in[9] + s0 + w_in[0];
    end

endmodule
`default_nettype wire

>>> rtl/core/sha256_stream_hasher.sv
`default_nettype none
// a byte word is taken in idle; one that completes a block gets 64 rounds and the add
// end of message: pad, rounds and add, again when the end word fills a block or the pad
// spills into a second block; then 8 digest words, one per cycle while out_stall is low
// no byte is taken outside idle; one shared round unit runs one round a cycle
// reset: hash words to initial values, counts to zero; block buffer is not cleared
module sha256_stream_hasher
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  msg_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [31:0] digest_word,
    output logic      [2:0]  word_index,
    output logic             last_word
);
    import sha_pkg::*;

    state_t state_reg, state_next;

    logic [31:0] hash_reg [8];
    logic [31:0] v_reg [8];
    // block buffer doubles as the rolling schedule window during rounds
    logic [31:0] w_reg [16];
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [5:0]  round_reg;
    logic        pend_end_reg;   // padding must follow the current compression
    logic        len_pend_reg;   // length-only block must follow the current compression
    logic        len_done_reg;   // current compression holds the length
    logic [2:0]  out_idx_reg;

    logic [31:0] v_rnd [8];
    logic [31:0] w_new;

    sha_round u_round
    (
        .v_in  (v_reg),
        .w_in  (w_reg),
        .k     (ROUND_K[round_reg]),
        .v_out (v_rnd),
        .w_new (w_new)
    );

    logic in_acc, out_acc;
    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (byte_present && fill_reg == 6'd63)
                        state_next = ST_ROUND;
                    else if (end_of_message)
                        state_next = ST_PAD;
                end
            end
            ST_ROUND: if (round_reg == 6'd63) state_next = ST_FINAL;
            ST_FINAL:
            begin
                if (len_done_reg)
                    state_next = ST_OUT;
                else if (pend_end_reg || len_pend_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_PAD: state_next = ST_ROUND;
            ST_OUT: if (out_acc && out_idx_reg == 3'd7) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall    = (state_reg != ST_IDLE);
        out_valid   = (state_reg == ST_OUT);
        digest_word = hash_reg[out_idx_reg];
        word_index  = out_idx_reg;
        last_word   = (out_idx_reg == 3'd7);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            bits_reg     <= '0;
            round_reg    <= '0;
            pend_end_reg <= 1'b0;
            len_pend_reg <= 1'b0;
            len_done_reg <= 1'b0;
            out_idx_reg  <= '0;
            for (int i = 0; i < 8; i++) hash_reg[i] <= INIT_H[i];
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (byte_present)
                        begin
                            w_reg[fill_reg[5:2]][8*(3-fill_reg[1:0]) +: 8] <= msg_byte;
                            bits_reg <= bits_reg + 64'd8;
                            fill_reg <= fill_reg + 6'd1;
                        end
                        pend_end_reg <= end_of_message;
                        round_reg    <= '0;
                        len_done_reg <= 1'b0;
                        for (int i = 0; i < 8; i++) v_reg[i] <= hash_reg[i];
                    end
                end
                ST_ROUND:
                begin
                    for (int i = 0; i < 8; i++) v_reg[i] <= v_rnd[i];
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= w_new;
                    round_reg <= round_reg + 6'd1;
                end
                ST_FINAL:
                begin
                    for (int i = 0; i < 8; i++) hash_reg[i] <= hash_reg[i] + v_reg[i];
                    for (int i = 0; i < 8; i++) v_reg[i] <= hash_reg[i] + v_reg[i];
                    if (!len_done_reg && pend_end_reg)
                        w_reg[0] <= 32'h0;   // fresh block when the end word filled the last one
                end
                ST_PAD:
                begin
                    // marker, zero fill and optional length in one sweep
                    round_reg <= '0;
                    if (pend_end_reg)
                    begin
                        pend_end_reg <= 1'b0;
                        for (int i = 0; i < 16; i++)
                        begin
                            if (i > int'(fill_reg[5:2]) && (i < 14 || fill_reg >= 6'd56))
                                w_reg[i] <= 32'h0;
                            else if (i == int'(fill_reg[5:2]))
                                w_reg[i] <= (w_reg[i] & ~(32'hFFFFFFFF >> (8*fill_reg[1:0])))
                                          | (32'h80000000 >> (8*fill_reg[1:0]));
                        end
                        if (fill_reg < 6'd56)
                        begin
                            w_reg[14] <= bits_reg[63:32];
                            w_reg[15] <= bits_reg[31:0];
                            len_done_reg <= 1'b1;
                            len_pend_reg <= 1'b0;
                        end
                        else
                        begin
                            len_done_reg <= 1'b0;
                            len_pend_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        // block after an overflow pad: zeros and the length
                        for (int i = 0; i < 14; i++) w_reg[i] <= 32'h0;
                        w_reg[14] <= bits_reg[63:32];
                        w_reg[15] <= bits_reg[31:0];
                        len_done_reg <= 1'b1;
                        len_pend_reg <= 1'b0;
                    end
                    fill_reg <= '0;
                end
                ST_OUT:
                begin
                    if (out_acc)
                    begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++) hash_reg[i] <= INIT_H[i];
                            bits_reg <= '0;
                            fill_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
            // full block finished with end pending: padding starts empty
            if (state_reg == ST_FINAL && !len_done_reg && pend_end_reg && fill_reg != 6'd0)
                fill_reg <= '0;
        end
    end

    // the block that holds the length goes straight to digest output, starting at word 0
    property p_final_out;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINAL && len_done_reg) |=> (state_reg == ST_OUT && out_idx_reg == 3'd0);
    endproperty
    a_final_out: assert property (p_final_out) else $error("digest not presented after length block");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_idx_reg));
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("digest word moved under stall");

    property p_round_wrap;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == 6'd63) |=> (state_reg == ST_FINAL);
    endproperty
    a_round_wrap: assert property (p_round_wrap) else $error("round count overran");

endmodule
`default_nettype wire

>>> tb/sv/sha256_stream_hasher_tb.sv
`timescale 1ns / 1ps
module sha256_stream_hasher_tb;

    // digest word as it leaves the hasher
    typedef struct {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_t;

    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  msg_byte;
    logic        byte_present;
    logic        end_of_message;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    sha256_stream_hasher u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .msg_byte      (msg_byte),
        .byte_present  (byte_present),
        .end_of_message(end_of_message),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .digest_word   (digest_word),
        .word_index    (word_index),
        .last_word     (last_word)
    );

    // round constants and initial hash values, kept locally
    logic [31:0] k_tab [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    logic [31:0] iv_tab [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    // predictor state
    logic [31:0] chain_h [8];
    logic [31:0] blk_w [16];
    int unsigned blk_fill;
    logic [63:0] msg_bits;

    digest_t     digest_q [$];
    int          errors;
    int          mismatches;
    int          words_in;
    int          words_out;
    int          digests_seen;
    int          idle_cycles;
    bit          hold_off;
    bit          drain_done;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_blk();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = blk_w[i];
        for (int i = 16; i < 64; i++)
            w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
               + k_tab[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endtask

    task automatic push_byte(logic [7:0] v);
        int sh;
        sh = (3 - (blk_fill % 4)) * 8;
        blk_w[blk_fill / 4] = (blk_w[blk_fill / 4] & ~(32'hFF << sh)) | ({24'h0, v} << sh);
        blk_fill++;
    endtask

    task automatic hash_restart();
        for (int i = 0; i < 8; i++)
            chain_h[i] = iv_tab[i];
        blk_fill = 0;
        msg_bits = '0;
    endtask

    // advance the predictor by one accepted word, queue digest words on end
    task automatic predict_digest(logic [7:0] b, logic pres, logic eom);
        digest_t r;
        if (pres)
        begin
            push_byte(b);
            msg_bits += 64'd8;
            if (blk_fill >= 64)
            begin
                compress_blk();
                blk_fill = 0;
            end
        end
        if (!eom)
            return;
        push_byte(8'h80);
        if (blk_fill > 56)
        begin
            while (blk_fill < 64)
                push_byte(8'h00);
            compress_blk();
            blk_fill = 0;
        end
        while (blk_fill < 56)
            push_byte(8'h00);
        blk_w[14] = msg_bits[63:32];
        blk_w[15] = msg_bits[31:0];
        compress_blk();
        for (int i = 0; i < 8; i++)
        begin
            r.digest_word = chain_h[i];
            r.word_index  = 3'(i);
            r.last_word   = (i == 7);
            digest_q.push_back(r);
        end
        hash_restart();
    endtask

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // sender: one word, random gap before it, held until accepted
    task automatic send_word(logic [7:0] b, logic pres, logic eom, int gap = -1);
        int g;
        g = (gap < 0) ? ((($urandom % 4) == 0) ? 0 : $urandom_range(0, 12)) : gap;
        repeat (g) @(negedge clk);
        in_valid        = 1'b1;
        msg_byte       <= b;
        byte_present   <= pres;
        end_of_message <= eom;
        do
            @(posedge clk);
        while (in_stall);
        predict_digest(b, pres, eom);
        words_in++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (digest_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_message(int len, bit lone_end);
        for (int i = 0; i < len; i++)
            send_word(8'($urandom), 1'b1, (i == len - 1) && !lone_end);
        if (lone_end || len == 0)
            send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    // receiver: random stall per word, long hold-off on request
    initial
    begin
        int g;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            g = (($urandom % 4) == 0) ? 0 : $urandom_range(0, 12);
            if (g != 0)
            begin
                out_stall <= 1'b1;
                repeat (g - 1) @(negedge clk);
                @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // checker: compare each accepted digest word with the oldest prediction
    always @(posedge clk)
    begin
        digest_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            words_out++;
            if (digest_q.size() == 0)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest word %h idx %0d", digest_word, word_index);
            end
            else
            begin
                e = digest_q.pop_front();
                if (e.last_word)
                    digests_seen++;
                if (digest_word !== e.digest_word || word_index !== e.word_index
                    || last_word !== e.last_word)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 e.digest_word, e.word_index, e.last_word,
                                 digest_word, word_index, last_word);
                end
            end
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (!drain_done)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_empty_message();
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'hFF, 1'b0, 1'b1);
    endtask

    task automatic test_byte_extremes();
        // idle words in the middle change nothing
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hA5, 1'b0, 1'b0);
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
    endtask

    task automatic test_pad_boundaries();
        // 56 bytes spills the padding into a second block, 64 on end compresses first
        send_message(56, 1'b0);
        send_message(64, 1'b0);
    endtask

    task automatic test_random_messages();
        int n;
        for (int m = 0; m < 3; m++)
        begin
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
            begin
                if (($urandom % 8) == 0)
                    send_word(8'($urandom), 1'b0, 1'b0);
                send_word(8'($urandom), 1'b1, 1'b0);
            end
            send_word(8'($urandom), 1'($urandom % 2), 1'b1);
        end
    endtask

    task automatic test_backpressure();
        // receiver holds off while messages keep flowing, input must stall
        hold_off = 1'b1;
        for (int m = 0; m < 2; m++)
        begin
            send_word(8'($urandom), 1'b1, 1'b0, 0);
            send_word(8'($urandom), 1'b1, 1'b1, 0);
        end
        wait_drained();
        // sender pause with everything drained
        send_message(1, 1'b0);
        wait_drained();
        send_message(1, 1'b1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        msg_byte = '0;
        byte_present = 1'b0;
        end_of_message = 1'b0;
        errors = 0;
        mismatches = 0;
        words_in = 0;
        words_out = 0;
        digests_seen = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        drain_done = 1'b0;
        for (int i = 0; i < 16; i++)
            blk_w[i] = '0;
        hash_restart();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_message();
        test_byte_extremes();
        test_pad_boundaries();
        test_random_messages();
        test_backpressure();

        wait_drained();
        repeat (200) @(negedge clk);
        drain_done = 1'b1;
        $display("sent %0d words, checked %0d digest words over %0d digests",
                 words_in, words_out, digests_seen);
        $display("covered empty messages, padding edges, idle words and output backpressure");
        if (errors == 0 && digest_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/sha_pkg.sv
rtl/core/sha_round.sv
rtl/core/sha256_stream_hasher.sv
tb/sv/sha256_stream_hasher_tb.sv
